// File: hw/rtl/rfpg_pkg.sv
package rfpg_pkg;

  // field widths fixed by the interface
  localparam int unsigned CFG_W = 7;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  // two-entry queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // radial ramp breakpoints
  localparam logic [PIX_W-1:0] D_LO       = 8'd5;
  localparam logic [PIX_W-1:0] D_RAMP_END = 8'd55;
  localparam logic [PIX_W-1:0] D_FALL_END = 8'd62;
  localparam logic [PIX_W-1:0] RAMP_STEP  = 8'd5;
  localparam logic [PIX_W-1:0] RAMP_BASE  = 8'd10;
  localparam logic [PIX_W-1:0] FALL_STEP  = 8'd36;
  localparam logic [PIX_W-1:0] FALL_TOP   = 8'd255;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic idle;
    logic done;
  } back_status_t;

  // intensity from integer distance; every value fits a byte
  function automatic logic [PIX_W-1:0] intensity(input logic [15:0] d);
    logic [PIX_W-1:0] t;
    t = '0;
    if (d < {8'd0, D_LO}) begin
      return '0;
    end else if (d < {8'd0, D_RAMP_END}) begin
      t = d[PIX_W-1:0] - D_LO;
      return PIX_W'(t * RAMP_STEP) + RAMP_BASE;
    end else if (d < {8'd0, D_FALL_END}) begin
      t = d[PIX_W-1:0] - D_RAMP_END;
      return FALL_TOP - PIX_W'(t * FALL_STEP);
    end else begin
      return '0;
    end
  endfunction

endpackage

// File: hw/rtl/rfpg_tick_if.sv
interface rfpg_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// File: hw/rtl/rfpg_pix_if.sv
interface rfpg_pix_if;
  logic                          valid;
  logic                          ready;
  logic [rfpg_pkg::PIX_W-1:0]    pixel_value;
  logic [rfpg_pkg::IDX_W-1:0]    pixel_index;
  logic                          last_pixel;

  modport source (output valid, output pixel_value, output pixel_index, output last_pixel,
                  input ready);
  modport sink (input valid, input pixel_value, input pixel_index, input last_pixel,
                output ready);
endinterface

// File: hw/rtl/radial_falloff_pixel_generator.sv
// Path: a tick beat enters the queue; the back end pops it, sums the squares,
//   forms K = clog2(MAX_DIM+1)+1 root digits bit-serially, then registers the pixel.
// The shared bit-serial square-root unit takes one entry at a time and waits while
//   the output is stalled; the two-entry queue absorbs bursts.
// Reset (async, active low): counters at pixel zero, both dimensions 64,
//   queue empty, no result pending.
module radial_falloff_pixel_generator #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rfpg_tick_if.sink                   tick_i,
  rfpg_pix_if.source                  pix_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfpg_pkg::APB_AW-1:0] paddr,
  input  logic [rfpg_pkg::APB_DW-1:0] pwdata,
  output logic [rfpg_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned ENTRY_W = 2 * DIM_W + rfpg_pkg::IDX_W + 1;

  // ---------------------------------------------------------------------
  // Configuration registers. Word address picks the register; byte
  // offset bits are ignored. Any write sends the raster back to origin.
  // ---------------------------------------------------------------------
  logic [rfpg_pkg::CFG_W-1:0] width_q, width_d, height_q, height_d;
  logic                       cfg_wr;
  rfpg_pkg::cfg_reg_e         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = rfpg_pkg::cfg_reg_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    unique case (cfg_sel)
      rfpg_pkg::REG_TEX_WIDTH: begin
        prdata = rfpg_pkg::APB_DW'(width_q);
        if (cfg_wr) begin
          width_d = pwdata[rfpg_pkg::CFG_W-1:0];
        end
      end
      rfpg_pkg::REG_TEX_HEIGHT: begin
        prdata = rfpg_pkg::APB_DW'(height_q);
        if (cfg_wr) begin
          height_d = pwdata[rfpg_pkg::CFG_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rfpg_pkg::DIM_RESET;
      height_q <= rfpg_pkg::DIM_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // ---------------------------------------------------------------------
  // Front end: raster counters, restart and wrap. One tick beat becomes
  // one queue entry holding the corner offsets, index and last flag.
  // ---------------------------------------------------------------------
  logic               q_full, q_push, q_valid, q_pop;
  logic [ENTRY_W-1:0] front_entry, q_entry;

  assign tick_i.ready = !q_full;
  assign q_push       = tick_i.valid && !q_full;

  rfpg_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .restart_i   (tick_i.restart),
    .cfg_clear_i (cfg_wr),
    .width_i     (width_q),
    .height_i    (height_q),
    .entry_o     (front_entry)
  );

  // Short queue so the front keeps counting while the root unit is busy.
  rfpg_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  // ---------------------------------------------------------------------
  // Back end: squares and sum, bit-serial root, ramp lookup, output reg.
  // ---------------------------------------------------------------------
  rfpg_pkg::back_status_t back_st;

  rfpg_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_ready_i (pix_o.ready),
    .out_valid_o (pix_o.valid),
    .out_value_o (pix_o.pixel_value),
    .out_index_o (pix_o.pixel_index),
    .out_last_o  (pix_o.last_pixel),
    .status_o    (back_st)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // back only takes an entry the queue actually holds
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back popped an empty queue");

  // a fresh result beat only comes out of the finishing state
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pix_o.valid) |-> $past(back_st.done))
    else $error("result beat without a finished root");

  // back end stays put while the queue is empty
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_st.idle && !q_valid) |=> back_st.idle)
    else $error("back end left idle with nothing queued");

endmodule

// File: hw/rtl/rfpg_front.sv
module rfpg_front #(
  parameter int unsigned MAX_DIM = 64,
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1),
  localparam int unsigned ENTRY_W = 2 * DIM_W + rfpg_pkg::IDX_W + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       restart_i,
  input  logic                       cfg_clear_i,
  input  logic [rfpg_pkg::CFG_W-1:0] width_i,
  input  logic [rfpg_pkg::CFG_W-1:0] height_i,
  output logic [ENTRY_W-1:0]         entry_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned CMP_W = (DIM_W > rfpg_pkg::CFG_W) ? DIM_W : rfpg_pkg::CFG_W;

  typedef struct packed {
    logic [DIM_W-1:0]           dy;
    logic [DIM_W-1:0]           dx;
    logic [rfpg_pkg::IDX_W-1:0] idx;
    logic                       last;
  } entry_t;

  // zero reads as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [rfpg_pkg::CFG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (ve > CMP_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(ve);
    end
  endfunction

  logic [CNT_W-1:0]           row_q, row_d, col_q, col_d, row_c, col_c;
  logic [rfpg_pkg::IDX_W-1:0] idx_q, idx_d, idx_c;
  logic [DIM_W-1:0]           w, h;
  logic [CNT_W-1:0]           w_m1, h_m1;
  logic                       last;
  entry_t                     entry;

  always_comb begin
    w     = eff_dim(width_i);
    h     = eff_dim(height_i);
    w_m1  = CNT_W'(w - DIM_W'(1));
    h_m1  = CNT_W'(h - DIM_W'(1));
    row_c = restart_i ? '0 : row_q;
    col_c = restart_i ? '0 : col_q;
    idx_c = restart_i ? '0 : idx_q;
    last  = (row_c == h_m1) && (col_c == w_m1);

    entry.dy   = h - DIM_W'(row_c);
    entry.dx   = w - DIM_W'(col_c);
    entry.idx  = idx_c;
    entry.last = last;
  end

  assign entry_o = entry;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    idx_d = idx_q;
    priority if (cfg_clear_i) begin
      row_d = '0;
      col_d = '0;
      idx_d = '0;
    end else if (push_i) begin
      if (last) begin
        row_d = '0;
        col_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_c + rfpg_pkg::IDX_W'(1);
        if (col_c == w_m1) begin
          col_d = '0;
          row_d = row_c + CNT_W'(1);
        end else begin
          col_d = col_c + CNT_W'(1);
          row_d = row_c;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      idx_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      idx_q <= idx_d;
    end
  end

endmodule

// File: hw/rtl/rfpg_queue.sv
module rfpg_queue #(
  parameter int unsigned WIDTH = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0]             mem_q [rfpg_pkg::Q_DEPTH];
  logic [rfpg_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [rfpg_pkg::Q_CNT_W-1:0] cnt_q;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == rfpg_pkg::Q_CNT_W'(rfpg_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + rfpg_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + rfpg_pkg::Q_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + rfpg_pkg::Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - rfpg_pkg::Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: hw/rtl/rfpg_back.sv
module rfpg_back #(
  parameter int unsigned MAX_DIM = 64,
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1),
  localparam int unsigned ENTRY_W = 2 * DIM_W + rfpg_pkg::IDX_W + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  logic [ENTRY_W-1:0]         q_entry_i,
  output logic                       q_pop_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [rfpg_pkg::PIX_W-1:0] out_value_o,
  output logic [rfpg_pkg::IDX_W-1:0] out_index_o,
  output logic                       out_last_o,
  output rfpg_pkg::back_status_t     status_o
);

  // squared distance width and number of root digits
  localparam int unsigned NW = 2 * DIM_W + 1;
  localparam int unsigned K  = DIM_W + 1;

  typedef struct packed {
    logic [DIM_W-1:0]           dy;
    logic [DIM_W-1:0]           dx;
    logic [rfpg_pkg::IDX_W-1:0] idx;
    logic                       last;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  entry_t                     entry;
  logic [NW-1:0]              rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [NW-1:0]              dy_x, dx_x;
  logic [NW:0]                trial;
  logic [rfpg_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                       last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  logic [rfpg_pkg::PIX_W-1:0] out_value_q, out_value_d;
  logic [rfpg_pkg::IDX_W-1:0] out_index_q, out_index_d;
  logic                       out_last_q, out_last_d;
  logic                       out_free;

  assign entry    = q_entry_i;
  assign dy_x     = NW'(entry.dy);
  assign dx_x     = NW'(entry.dx);
  assign trial    = {1'b0, root_q} + {1'b0, bit_q};
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    root_d      = root_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_index_d = out_index_q;
    out_last_d  = out_last_q;
    q_pop_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rem_d   = NW'(dy_x * dy_x) + NW'(dx_x * dx_x);
          root_d  = '0;
          bit_d   = NW'(1) << (2 * (K - 1));
          idx_d   = entry.idx;
          last_d  = entry.last;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        // one root digit per cycle, restoring form
        if ({1'b0, rem_q} >= trial) begin
          rem_d  = rem_q - trial[NW-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == NW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = rfpg_pkg::intensity(16'(root_q));
          out_index_d = idx_q;
          out_last_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    root_q      <= root_d;
    bit_q       <= bit_d;
    idx_q       <= idx_d;
    last_q      <= last_d;
    out_value_q <= out_value_d;
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_index_o   = out_index_q;
  assign out_last_o    = out_last_q;
  assign status_o.idle = (state_q == ST_IDLE);
  assign status_o.done = (state_q == ST_DONE);

endmodule
